>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files; gbnc_engine includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define GBNC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be seen outside reset.
`define GBNC_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/gbnc_pkg.sv
// ----------------------------------------------------------------------------
// gbnc_pkg
// Types, codes and constants of the Go-Back-N sender window engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gbnc_pkg;

    localparam int DEF_MAX_WINDOW = 32;
    localparam int DEF_SEQ_BITS   = 16;

    localparam int CWND_W       = 14;
    localparam int CNT_W        = 6;
    localparam int RESULT_LIMIT = 32;
    localparam int DIV_NUM_W    = 17;
    localparam int DIV_STEPS    = 17;
    localparam int DIV_STEP_W   = 5;
    localparam int QUO_W        = 9;

    localparam logic [CWND_W-1:0] Q_ONE          = 14'd256;
    localparam logic [CWND_W-1:0] SSTHRESH_RESET = 14'd4096;

    localparam logic [1:0] MODE_STOP_WAIT  = 2'd0;
    localparam logic [1:0] MODE_FIXED      = 2'd1;
    localparam logic [1:0] MODE_CONGESTION = 2'd2;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SEGMENTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RETX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RECOVERY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  window_size;
        logic [15:0] total_segments;
        logic        fast_retransmit_on;
        logic        fast_recovery_on;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] ack_number;
    } req_t;

    typedef struct packed {
        logic              start;
        logic [CWND_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> rtl/gbnc_if.sv
// ----------------------------------------------------------------------------
// gbnc_item_if / gbnc_result_if
// Valid/ready channels for input events and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbnc_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] ack_number;

    modport source (output valid, output opcode, output ack_number, input ready);
    modport sink   (input valid, input opcode, input ack_number, output ready);
endinterface

interface gbnc_result_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [15:0] send_sequence;
    logic        is_retransmit;
    logic        last_of_run;
    logic        transfer_done;
    logic [13:0] window_now;

    modport source (output valid, output send_valid, output send_sequence,
                    output is_retransmit, output last_of_run, output transfer_done,
                    output window_now, input ready);
    modport sink   (input valid, input send_valid, input send_sequence,
                    input is_retransmit, input last_of_run, input transfer_done,
                    input window_now, output ready);
endinterface

`default_nettype wire

>>> rtl/gbnc_in_queue.sv
// ----------------------------------------------------------------------------
// gbnc_in_queue
// Two-entry request queue between the input channel and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module gbnc_in_queue (
    input  logic          clk,
    input  logic          rst_n,
    gbnc_item_if.sink     item,
    output logic          req_valid,
    output gbnc_pkg::req_t req,
    input  logic          req_ready
);
    import gbnc_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign item.ready = (count_reg != 2'd2);
    assign push       = item.valid && item.ready;
    assign req_valid  = (count_reg != 2'd0);
    assign pop        = req_valid && req_ready;
    assign req        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{opcode: item.opcode, ack_number: item.ack_number};
        end
    end

endmodule

`default_nettype wire

>>> rtl/gbnc_recip_div.sv
// ----------------------------------------------------------------------------
// gbnc_recip_div
// Restoring divider for floor(65536 / divisor), one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gbnc_recip_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gbnc_pkg::div_req_t dreq,
    output gbnc_pkg::div_rsp_t drsp
);
    import gbnc_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_STEP_W-1:0] step_next;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_NUM_W-1:0]  num_next;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic [DIV_NUM_W-1:0]  quo_next;
    logic [CWND_W-1:0]     rem_reg;
    logic [CWND_W-1:0]     rem_next;
    logic [CWND_W-1:0]     d_reg;
    logic [CWND_W-1:0]     d_next;
    logic [CWND_W:0]       trial;
    logic                  fits;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (dreq.start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(DIV_STEPS);
            num_next  = DIV_NUM_W'(1) << 16;
            quo_next  = '0;
            rem_next  = '0;
            d_next    = dreq.divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits its width.
            rem_next  = fits ? CWND_W'(trial - {1'b0, d_reg}) : trial[CWND_W-1:0];
            quo_next  = {quo_reg[DIV_NUM_W-2:0], fits};
            num_next  = {num_reg[DIV_NUM_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign drsp.done     = done_reg;
    assign drsp.quotient = quo_reg[QUO_W-1:0];

endmodule

`default_nettype wire

>>> rtl/gbnc_engine.sv
// ----------------------------------------------------------------------------
// gbnc_engine
// Window state, congestion control update and result sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gbnc_engine #(
    parameter int MAX_WINDOW = gbnc_pkg::DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = gbnc_pkg::DEF_SEQ_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gbnc_pkg::cfg_t     cfg,
    input  logic               req_valid,
    input  gbnc_pkg::req_t     req,
    output logic               req_ready,
    output gbnc_pkg::div_req_t div_req,
    input  gbnc_pkg::div_rsp_t div_rsp,
    gbnc_result_if.source      result
);
    import gbnc_pkg::*;

    localparam int SW = SEQ_BITS;
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam logic [31:0] SEQ_MASK32 = 32'((64'd1 << SEQ_BITS) - 64'd1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CWND = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [SW-1:0]     base_reg, base_next;
    logic [SW-1:0]     nxt_reg, nxt_next;
    logic [1:0]        dup_reg, dup_next;
    logic [CWND_W-1:0] cwnd_reg, cwnd_next;
    logic [CWND_W-1:0] ssth_reg, ssth_next;
    logic              trun_reg, trun_next;
    logic [15:0]       trem_reg, trem_next;
    logic              rtx_act_reg, rtx_act_next;
    logic [SW-1:0]     rtx_ptr_reg, rtx_ptr_next;
    logic [SW-1:0]     rtx_end_reg, rtx_end_next;
    logic [SW-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;

    logic              ov_reg, ov_next;
    logic              o_send_reg, o_send_next;
    logic [15:0]       o_seq_reg, o_seq_next;
    logic              o_rtx_reg, o_rtx_next;
    logic              o_last_reg, o_last_next;
    logic              o_done_reg, o_done_next;
    logic [CWND_W-1:0] o_win_reg, o_win_next;

    logic [31:0]       tot32;
    logic [SW-1:0]     total;
    logic [5:0]        recv;
    logic [15:0]       tt_eff;
    logic [8:0]        w9;
    logic [5:0]        cw_int;
    logic [5:0]        cw_min;
    logic [WW-1:0]     wwin;
    logic [SW:0]       limit;
    logic [CWND_W-1:0] half;
    logic [CWND_W-1:0] ssth_half;
    logic [CWND_W-1:0] cap;
    logic [CWND_W-1:0] c_cur;
    logic [CWND_W:0]   c_step;
    logic              c_apply;
    logic [31:0]       ack_a;
    logic [SW-1:0]     ack_sat;
    logic [1:0]        dup_inc;
    logic              rtx_now;
    logic              new_now;
    logic              more_rtx;
    logic              more_new;
    logic              n_room;
    logic              n_room2;
    logic              out_free;

    assign tot32  = 32'(cfg.total_segments);
    assign total  = (tot32 > SEQ_MASK32) ? SEQ_MASK32[SW-1:0] : tot32[SW-1:0];
    assign recv   = (cfg.window_size == 6'd0) ? 6'd1 : cfg.window_size;
    assign tt_eff = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
    assign cw_int = cwnd_reg[CWND_W-1:8];
    assign cw_min = (cw_int < recv) ? cw_int : recv;

    always_comb
    begin
        unique case (cfg.mode)
            MODE_STOP_WAIT:  w9 = 9'd1;
            MODE_CONGESTION: w9 = (cw_min == 6'd0) ? 9'd1 : 9'(cw_min);
            default:         w9 = 9'(recv);
        endcase
    end

    assign wwin  = (w9 > 9'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : WW'(w9);
    assign limit = {1'b0, base_reg} + (SW+1)'(wwin);

    assign half      = cwnd_reg >> 1;
    assign ssth_half = (half < Q_ONE) ? Q_ONE : half;
    assign cap       = {recv, 8'd0};
    assign c_cur     = (cwnd_reg < Q_ONE) ? Q_ONE : cwnd_reg;

    assign ack_a   = (32'(req.ack_number) > 32'(total)) ? 32'(total) : 32'(req.ack_number);
    assign ack_sat = (ack_a > 32'(nxt_reg)) ? nxt_reg : ack_a[SW-1:0];
    assign dup_inc = (dup_reg == 2'd3) ? 2'd3 : dup_reg + 2'd1;

    // Results of one request are produced in order: retransmissions, then new sends.
    assign n_room   = (n_reg < CNT_W'(RESULT_LIMIT));
    assign n_room2  = (n_reg < CNT_W'(RESULT_LIMIT - 1));
    assign rtx_now  = rtx_act_reg && (rtx_ptr_reg < rtx_end_reg) && n_room;
    assign new_now  = (nxt_reg < total) && ({1'b0, nxt_reg} < limit) && n_room;
    assign more_rtx = ((SW+1)'(rtx_ptr_reg) + 1'b1 < (SW+1)'(rtx_end_reg)) && n_room2;
    assign more_new = rtx_now
                      ? ((nxt_reg < total) && ({1'b0, nxt_reg} < limit) && n_room2)
                      : (((SW+1)'(nxt_reg) + 1'b1 < (SW+1)'(total))
                         && ((SW+1)'(nxt_reg) + 1'b1 < limit) && n_room2);
    assign out_free = !ov_reg || result.ready;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        base_next    = base_reg;
        nxt_next     = nxt_reg;
        dup_next     = dup_reg;
        cwnd_next    = cwnd_reg;
        ssth_next    = ssth_reg;
        trun_next    = trun_reg;
        trem_next    = trem_reg;
        rtx_act_next = rtx_act_reg;
        rtx_ptr_next = rtx_ptr_reg;
        rtx_end_next = rtx_end_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        ov_next      = ov_reg && !result.ready;
        o_send_next  = o_send_reg;
        o_seq_next   = o_seq_reg;
        o_rtx_next   = o_rtx_reg;
        o_last_next  = o_last_reg;
        o_done_next  = o_done_reg;
        o_win_next   = o_win_reg;
        div_req      = '{start: 1'b0, divisor: c_cur};
        c_step       = '0;
        c_apply      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    n_next       = '0;
                    rtx_act_next = 1'b0;
                    state_next   = ST_EMIT;
                    if (base_reg < total)
                    begin
                        if (req.opcode == OP_TICK)
                        begin
                            if (trun_reg)
                            begin
                                if (trem_reg > 16'd1)
                                begin
                                    trem_next = trem_reg - 16'd1;
                                end
                                else
                                begin
                                    if (cfg.mode == MODE_CONGESTION)
                                    begin
                                        ssth_next = ssth_half;
                                        cwnd_next = Q_ONE;
                                    end
                                    rtx_act_next = 1'b1;
                                    rtx_ptr_next = base_reg;
                                    rtx_end_next = nxt_reg;
                                    dup_next     = 2'd0;
                                    trun_next    = 1'b1;
                                    trem_next    = tt_eff;
                                end
                            end
                        end
                        else if (ack_sat > base_reg)
                        begin
                            base_next = ack_sat;
                            dup_next  = 2'd0;
                            cnt_next  = ack_sat - base_reg;
                            if (ack_sat == nxt_reg)
                            begin
                                trun_next = 1'b0;
                                trem_next = 16'd0;
                            end
                            else
                            begin
                                trun_next = 1'b1;
                                trem_next = tt_eff;
                            end
                            if (cfg.mode == MODE_CONGESTION)
                            begin
                                state_next = ST_CWND;
                            end
                        end
                        else if ((ack_sat == base_reg) && (base_reg < nxt_reg))
                        begin
                            dup_next = dup_inc;
                            if (cfg.fast_retransmit_on && (dup_inc == 2'd3))
                            begin
                                rtx_act_next = 1'b1;
                                rtx_ptr_next = base_reg;
                                rtx_end_next = base_reg + 1'b1;
                                dup_next     = 2'd0;
                                if (cfg.mode == MODE_CONGESTION)
                                begin
                                    ssth_next = ssth_half;
                                    cwnd_next = cfg.fast_recovery_on ? ssth_half : Q_ONE;
                                end
                            end
                        end
                    end
                end
            end

            ST_CWND:
            begin
                if (c_cur < ssth_reg)
                begin
                    c_step  = {1'b0, c_cur} + {1'b0, Q_ONE};
                    c_apply = 1'b1;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    c_step  = {1'b0, c_cur} + (CWND_W+1)'(div_rsp.quotient);
                    c_apply = 1'b1;
                end
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_done_next = (base_reg >= total);
                    o_win_next  = cwnd_reg;
                    n_next      = n_reg + 1'b1;
                    if (rtx_now)
                    begin
                        o_send_next  = 1'b1;
                        o_seq_next   = 16'(rtx_ptr_reg);
                        o_rtx_next   = 1'b1;
                        o_last_next  = !(more_rtx || more_new);
                        rtx_ptr_next = rtx_ptr_reg + 1'b1;
                    end
                    else if (new_now)
                    begin
                        o_send_next = 1'b1;
                        o_seq_next  = 16'(nxt_reg);
                        o_rtx_next  = 1'b0;
                        o_last_next = !more_new;
                        nxt_next    = nxt_reg + 1'b1;
                        if (!trun_reg)
                        begin
                            trun_next = 1'b1;
                            trem_next = tt_eff;
                        end
                    end
                    else
                    begin
                        // Nothing to send: a single status result closes the request.
                        o_send_next = 1'b0;
                        o_seq_next  = 16'd0;
                        o_rtx_next  = 1'b0;
                        o_last_next = 1'b1;
                    end
                    if (o_last_next)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // One additive increase step; reaching the receiver cap ends the update.
        if (c_apply)
        begin
            if (c_step >= {1'b0, cap})
            begin
                cwnd_next  = cap;
                state_next = ST_EMIT;
            end
            else
            begin
                cwnd_next  = c_step[CWND_W-1:0];
                cnt_next   = cnt_reg - 1'b1;
                state_next = (cnt_reg == SW'(1)) ? ST_EMIT : ST_CWND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            base_reg    <= '0;
            nxt_reg     <= '0;
            dup_reg     <= 2'd0;
            cwnd_reg    <= Q_ONE;
            ssth_reg    <= SSTHRESH_RESET;
            trun_reg    <= 1'b0;
            trem_reg    <= 16'd0;
            rtx_act_reg <= 1'b0;
            n_reg       <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            nxt_reg     <= nxt_next;
            dup_reg     <= dup_next;
            cwnd_reg    <= cwnd_next;
            ssth_reg    <= ssth_next;
            trun_reg    <= trun_next;
            trem_reg    <= trem_next;
            rtx_act_reg <= rtx_act_next;
            n_reg       <= n_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtx_ptr_reg <= rtx_ptr_next;
        rtx_end_reg <= rtx_end_next;
        cnt_reg     <= cnt_next;
        o_send_reg  <= o_send_next;
        o_seq_reg   <= o_seq_next;
        o_rtx_reg   <= o_rtx_next;
        o_last_reg  <= o_last_next;
        o_done_reg  <= o_done_next;
        o_win_reg   <= o_win_next;
    end

    assign result.valid         = ov_reg;
    assign result.send_valid    = o_send_reg;
    assign result.send_sequence = o_seq_reg;
    assign result.is_retransmit = o_rtx_reg;
    assign result.last_of_run   = o_last_reg;
    assign result.transfer_done = o_done_reg;
    assign result.window_now    = o_win_reg;

    `GBNC_ASSERT(a_base_le_next, clk, rst_n, base_reg <= nxt_reg, "send base passed next sequence")
    `GBNC_ASSERT(a_cwnd_floor, clk, rst_n, cwnd_reg >= Q_ONE, "cwnd fell below one segment")
    `GBNC_NEVER(a_result_limit, clk, rst_n, (state_reg == ST_EMIT) && (n_reg > CNT_W'(RESULT_LIMIT)), "too many results for one request")
    `GBNC_NEVER(a_req_while_busy, clk, rst_n, req_ready && (state_reg != ST_IDLE), "request taken while busy")

endmodule

`default_nettype wire

>>> rtl/gbn_sender_congestion_window_core.sv
// ----------------------------------------------------------------------------
// gbn_sender_congestion_window_core
// Go-Back-N sender window engine with Reno-style congestion control.
// ----------------------------------------------------------------------------
// Each request is a timer tick or a cumulative ACK; the engine answers with one
// result per segment to transmit, or a single status result, the final one
// marked last_of_run. Requests are handled one at a time behind a two-entry
// queue: the engine classifies a request, then emits its results, stalling
// while the result channel is not ready.
// In congestion mode an ACK that advances the base adds one cwnd update step
// per acknowledged segment, made directly in slow start and through the
// one-bit-per-cycle reciprocal divider in congestion avoidance; the
// update stops early when cwnd reaches the receiver cap.
`default_nettype none

module gbn_sender_congestion_window_core #(
    parameter int MAX_WINDOW = gbnc_pkg::DEF_MAX_WINDOW,
    parameter int SEQ_BITS   = gbnc_pkg::DEF_SEQ_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    gbnc_item_if.sink                          item,
    gbnc_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [gbnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                        cfg_data
);
    import gbnc_pkg::*;

    cfg_t     cfg_reg;
    logic     req_valid;
    req_t     req;
    logic     req_ready;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: MODE_FIXED, window_size: 6'd4, total_segments: 16'd1,
                         fast_retransmit_on: 1'b0, fast_recovery_on: 1'b0,
                         timeout_ticks: 16'd1000};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:           cfg_reg.mode               <= cfg_data[1:0];
                CFG_WINDOW_SIZE:    cfg_reg.window_size        <= cfg_data[5:0];
                CFG_TOTAL_SEGMENTS: cfg_reg.total_segments     <= cfg_data;
                CFG_FAST_RETX:      cfg_reg.fast_retransmit_on <= cfg_data[0];
                CFG_FAST_RECOVERY:  cfg_reg.fast_recovery_on   <= cfg_data[0];
                CFG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks      <= cfg_data;
                default:            cfg_reg                    <= cfg_reg;
            endcase
        end
    end

    gbnc_in_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    gbnc_recip_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .dreq  (div_req),
        .drsp  (div_rsp)
    );

    gbnc_engine #(
        .MAX_WINDOW (MAX_WINDOW),
        .SEQ_BITS   (SEQ_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> test/tb_gbn_sender_congestion_window_core.sv
// ----------------------------------------------------------------------------
// tb_gbn_sender_congestion_window_core
// Self-checking bench for the Go-Back-N sender window engine. A behavioral
// window model in a small scoreboard class predicts every send and status
// result per accepted request. The run covers all modes, window extremes,
// timeouts, fast retransmit and recovery, under random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gbn_sender_congestion_window_core;
    import gbnc_pkg::*;

    typedef struct {
        bit        send_valid;
        bit [15:0] send_sequence;
        bit        is_retransmit;
        bit        last_of_run;
        bit        transfer_done;
        bit [13:0] window_now;
    } send_rec_t;

    class gbn_scoreboard;
        bit [1:0]  mode;
        bit [5:0]  window_size;
        bit [15:0] total_segments;
        bit        fast_rtx;
        bit        fast_recovery;
        bit [15:0] timeout_ticks;

        int unsigned send_base;
        int unsigned next_seq;
        int unsigned dup_count;
        int unsigned cwnd;
        int unsigned ssthresh;
        bit          timer_on;
        int unsigned timer_left;

        send_rec_t expected_sends[$];
        int        errors;

        function new();
            mode = MODE_FIXED;
            window_size = 4;
            total_segments = 1;
            fast_rtx = 0;
            fast_recovery = 0;
            timeout_ticks = 1000;
            send_base = 0;
            next_seq = 0;
            dup_count = 0;
            cwnd = 256;
            ssthresh = 4096;
            timer_on = 0;
            timer_left = 0;
            errors = 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        function void configure(bit [CFG_IDX_W-1:0] idx, bit [15:0] value);
            case (idx)
                CFG_MODE:           mode = value[1:0];
                CFG_WINDOW_SIZE:    window_size = value[5:0];
                CFG_TOTAL_SEGMENTS: total_segments = value;
                CFG_FAST_RETX:      fast_rtx = value[0];
                CFG_FAST_RECOVERY:  fast_recovery = value[0];
                CFG_TIMEOUT_TICKS:  timeout_ticks = value;
                default: ;
            endcase
        endfunction

        function int unsigned rx_cap();
            return (window_size == 0) ? 1 : window_size;
        endfunction

        function int unsigned send_window();
            int unsigned w;
            if (mode == MODE_STOP_WAIT)
                w = 1;
            else if (mode == MODE_CONGESTION) begin
                w = cwnd >> 8;
                if (w > rx_cap()) w = rx_cap();
                if (w < 1) w = 1;
            end
            else
                w = rx_cap();
            return (w > 32) ? 32 : w;
        endfunction

        function void restart_timer();
            timer_on = 1;
            timer_left = (timeout_ticks == 0) ? 1 : timeout_ticks;
        endfunction

        function void cut_threshold();
            int unsigned h;
            h = cwnd >> 1;
            ssthresh = (h < 256) ? 256 : h;
        endfunction

        // Works out the run of results that one accepted request causes.
        function void note_request(bit op, bit [15:0] ack_in);
            send_rec_t   run[$];
            send_rec_t   r;
            int unsigned total;
            int unsigned ack;
            int unsigned adv;
            int unsigned c;
            int unsigned w;
            total = total_segments;
            r = '{default: 0};
            if (send_base < total) begin
                if (op == OP_TICK) begin
                    if (timer_on) begin
                        if (timer_left > 1)
                            timer_left--;
                        else begin
                            if (mode == MODE_CONGESTION) begin
                                cut_threshold();
                                cwnd = 256;
                            end
                            for (int unsigned s = send_base; s < next_seq && run.size() < 32;
                                 s++) begin
                                r.send_valid = 1; r.send_sequence = s; r.is_retransmit = 1;
                                run.push_back(r);
                            end
                            dup_count = 0;
                            restart_timer();
                        end
                    end
                end
                else begin
                    ack = ack_in;
                    if (ack > total) ack = total;
                    if (ack > next_seq) ack = next_seq;
                    if (ack > send_base) begin
                        adv = ack - send_base;
                        send_base = ack;
                        dup_count = 0;
                        if (mode == MODE_CONGESTION) begin
                            for (int unsigned i = 0; i < adv; i++) begin
                                c = (cwnd < 256) ? 256 : cwnd;
                                if (c < ssthresh) c += 256;
                                else c += 65536 / c;
                                if (c >= rx_cap() * 256) begin
                                    cwnd = rx_cap() * 256;
                                    break;
                                end
                                cwnd = c;
                            end
                        end
                        if (send_base == next_seq) begin
                            timer_on = 0;
                            timer_left = 0;
                        end
                        else
                            restart_timer();
                    end
                    else if (ack == send_base && send_base < next_seq) begin
                        if (dup_count < 3) dup_count++;
                        if (fast_rtx && dup_count == 3) begin
                            r.send_valid = 1; r.send_sequence = send_base; r.is_retransmit = 1;
                            run.push_back(r);
                            if (mode == MODE_CONGESTION) begin
                                cut_threshold();
                                cwnd = fast_recovery ? ssthresh : 256;
                            end
                            dup_count = 0;
                        end
                    end
                end
                if (send_base < total) begin
                    w = send_window();
                    while (next_seq < total && next_seq < send_base + w && run.size() < 32)
                    begin
                        r.send_valid = 1; r.send_sequence = next_seq; r.is_retransmit = 0;
                        run.push_back(r);
                        if (!timer_on) restart_timer();
                        next_seq++;
                    end
                end
            end
            if (run.size() == 0) begin
                r = '{default: 0};
                run.push_back(r);
            end
            foreach (run[k]) begin
                run[k].last_of_run = (k == run.size() - 1);
                run[k].transfer_done = (send_base >= total);
                run[k].window_now = cwnd[13:0];
                expected_sends.push_back(run[k]);
            end
        endfunction

        task check_result(send_rec_t got);
            send_rec_t want;
            if (expected_sends.size() == 0) begin
                report($sformatf("unexpected result seq %0d", got.send_sequence));
                return;
            end
            want = expected_sends.pop_front();
            if (got.send_valid != want.send_valid)
                report($sformatf("send_valid %0d, want %0d", got.send_valid, want.send_valid));
            if (got.send_sequence != want.send_sequence)
                report($sformatf("send_sequence %0d, want %0d",
                                 got.send_sequence, want.send_sequence));
            if (got.is_retransmit != want.is_retransmit)
                report($sformatf("is_retransmit %0d, want %0d (seq %0d)",
                                 got.is_retransmit, want.is_retransmit, want.send_sequence));
            if (got.last_of_run != want.last_of_run)
                report($sformatf("last_of_run %0d, want %0d",
                                 got.last_of_run, want.last_of_run));
            if (got.transfer_done != want.transfer_done)
                report($sformatf("transfer_done %0d, want %0d",
                                 got.transfer_done, want.transfer_done));
            if (got.window_now != want.window_now)
                report($sformatf("window_now %0d, want %0d", got.window_now, want.window_now));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    gbnc_item_if   item_ch();
    gbnc_result_if result_ch();

    gbn_scoreboard sb;
    int            sender_idle_pct;
    int            receiver_stall_pct;

    gbn_sender_congestion_window_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side: random stalls, and every accepted result goes to the checker.
    always @(posedge clk)
    begin
        send_rec_t got;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            got.send_valid    = result_ch.send_valid;
            got.send_sequence = result_ch.send_sequence;
            got.is_retransmit = result_ch.is_retransmit;
            got.last_of_run   = result_ch.last_of_run;
            got.transfer_done = result_ch.transfer_done;
            got.window_now    = result_ch.window_now;
            sb.check_result(got);
        end
        result_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task cfg_write(bit [CFG_IDX_W-1:0] idx, bit [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.configure(idx, value);
    endtask

    task send_request(bit op, bit [15:0] ack);
        int gap;
        gap = ($urandom_range(0, 99) < sender_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.opcode     <= op;
        item_ch.ack_number <= ack;
        do @(posedge clk); while (!item_ch.ready);
        sb.note_request(op, ack);
    endtask

    // Mostly plausible ACKs around the window, with ticks and some noise.
    task send_random_request();
        int          r;
        int unsigned span;
        r = $urandom_range(0, 99);
        span = sb.next_seq - sb.send_base;
        if (r < 30)
            send_request(OP_TICK, $urandom_range(0, 65535));
        else if (r < 55)
            send_request(OP_ACK, sb.send_base);
        else if (r < 88)
            send_request(OP_ACK, sb.send_base + $urandom_range(0, span));
        else
            send_request(OP_ACK, $urandom_range(0, 65535));
    endtask

    task drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_sends.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        bit [1:0]  ph_mode [8]    = '{MODE_STOP_WAIT, MODE_FIXED, MODE_CONGESTION, 2'd3,
                                      MODE_CONGESTION, MODE_CONGESTION, MODE_FIXED,
                                      MODE_CONGESTION};
        bit [5:0]  ph_window [8]  = '{1, 0, 63, 5, 32, 8, 17, 2};
        bit        ph_frt [8]     = '{0, 1, 1, 1, 0, 1, 1, 1};
        bit        ph_frec [8]    = '{0, 0, 1, 0, 0, 1, 1, 0};
        bit [15:0] ph_timeout [8] = '{0, 2, 5, 65535, 1, 4, 3, 7};
        int        ph_extra [8]   = '{40, 40, 40, 1, 40, 40, 40, 0};
        bit [15:0] total;
        sb = new();
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 0;
        item_ch.opcode = OP_TICK;
        item_ch.ack_number = '0;
        result_ch.ready = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed opening: sends, duplicates, fast retransmit, timeout, saturation.
        cfg_write(CFG_TOTAL_SEGMENTS, 20);
        cfg_write(CFG_FAST_RETX, 1);
        cfg_write(CFG_TIMEOUT_TICKS, 3);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_request(OP_ACK, 16'd0);
        send_request(OP_TICK, 16'hFFFF);
        send_request(OP_ACK, 16'd0);
        send_request(OP_ACK, 16'd0);
        send_request(OP_ACK, 16'd0);
        send_request(OP_ACK, 16'd2);
        send_request(OP_ACK, 16'd1);
        send_request(OP_ACK, 16'hFFFF);
        send_request(OP_TICK, 16'd0);
        send_request(OP_TICK, 16'd0);
        send_request(OP_TICK, 16'd0);
        send_request(OP_TICK, 16'd0);
        send_request(OP_TICK, 16'd0);
        send_request(OP_ACK, 16'h8000);
        send_request(OP_ACK, 16'h7FFF);
        drain();

        for (int p = 0; p < 8; p++) begin
            total = (ph_extra[p] == 0) ? 16'hFFFF : 16'(sb.send_base + ph_extra[p]);
            cfg_write(CFG_MODE, ph_mode[p]);
            cfg_write(CFG_WINDOW_SIZE, ph_window[p]);
            cfg_write(CFG_TOTAL_SEGMENTS, total);
            cfg_write(CFG_FAST_RETX, ph_frt[p]);
            cfg_write(CFG_FAST_RECOVERY, ph_frec[p]);
            cfg_write(CFG_TIMEOUT_TICKS, ph_timeout[p]);
            cfg_we <= 1'b0;
            @(posedge clk);
            case (p % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
                default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
            endcase
            for (int n = 0; n < 38; n++) send_random_request();
            drain();
        end

        if (sb.errors == 0 && sb.expected_sends.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
